/* design/dfim_pkg.sv */
// dfim_pkg: widths, reset values, register indexes, item codes and payload
// types of the depth filtered interval merge core.
// Depends on nothing; used by the channel interface and the core.
`default_nettype none

package dfim_pkg;

   // field widths
   localparam int unsigned PosWidth    = 31;
   localparam int unsigned DepthWidth  = 31;
   localparam int unsigned SeqWidth    = 16;
   localparam int unsigned PloidyWidth = 4;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDataWidth = 31;

   // register reset values
   localparam logic [DepthWidth-1:0] DepthThresholdReset = DepthWidth'(10);
   localparam logic [PosWidth-1:0]   MergeGapReset       = '0;
   localparam logic                  MergeEnableReset    = 1'b1;

   // register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEPTH_THRESHOLD = 2'd0,
      CSR_MERGE_GAP       = 2'd1,
      CSR_MERGE_ENABLE    = 2'd2
   } csr_index_type;

   // item kind codes
   typedef enum logic {
      KIND_RECORD = 1'b0,
      KIND_FLUSH  = 1'b1
   } kind_type;

   typedef struct packed {
      logic                   kind;
      logic [DepthWidth-1:0]  read_depth;
      logic [SeqWidth-1:0]    seq_id;
      logic [PosWidth-1:0]    start_pos;
      logic [PosWidth-1:0]    end_pos;
      logic [PloidyWidth-1:0] ploidy;
   } req_payload_type;

   typedef struct packed {
      logic [SeqWidth-1:0]    out_seq_id;
      logic [PosWidth-1:0]    out_start;
      logic [PosWidth-1:0]    out_end;
      logic [PloidyWidth-1:0] out_ploidy;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* design/dfim_stream_if.sv */
// dfim_stream_if: valid/ready channel carrying one payload per item.
// The payload type is a parameter; defaults come from dfim_pkg.
`default_nettype none

interface dfim_stream_if #(
   parameter type payload_type = dfim_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/depth_filtered_interval_merge_core.sv */
// depth_filtered_interval_merge_core: depth filter and gap merge of sorted
// variant records into intervals. Uses dfim_pkg and dfim_stream_if.
`default_nettype none

//  channel | direction | payload                                   | handshake
//  req     | in        | kind, read_depth, seq_id, start_pos,      | valid/ready
//          |           | end_pos, ploidy                           |
//  rsp     | out       | out_seq_id, out_start, out_end, out_ploidy| valid/ready
//  csr     | in        | csr_index, csr_wr_data                    | csr_wr_en
//
//  One item is taken each cycle while req is ready; its compare and window
//  update finish in the cycle it is accepted and any interval goes to the
//  result register, or the skid while that is held. A two-entry output buffer
//  (result register plus skid) keeps req ready while one interval waits; req
//  drops ready only when both are full. Synchronous active-high reset clears
//  the window and the buffer valid bits and loads the register reset values.

module depth_filtered_interval_merge_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   dfim_stream_if.sink                             req,
   dfim_stream_if.source                           rsp,
   input  wire logic                               csr_wr_en,
   input  wire logic [dfim_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [dfim_pkg::CsrDataWidth-1:0]  csr_wr_data
);

   // configuration registers
   logic [dfim_pkg::DepthWidth-1:0] depth_threshold_ff;
   logic [dfim_pkg::PosWidth-1:0]   merge_gap_ff;
   logic                            merge_enable_ff;

   // window state
   logic                             window_open_ff,   window_open_in;
   logic [dfim_pkg::SeqWidth-1:0]    window_seq_ff,    window_seq_in;
   logic [dfim_pkg::PosWidth-1:0]    window_start_ff,  window_start_in;
   logic [dfim_pkg::PosWidth-1:0]    window_end_ff,    window_end_in;
   logic [dfim_pkg::PloidyWidth-1:0] window_ploidy_ff, window_ploidy_in;

   // output buffer
   logic                      out_valid_ff,  out_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   dfim_pkg::rsp_payload_type out_data_ff,   out_data_in;
   dfim_pkg::rsp_payload_type skid_data_ff,  skid_data_in;

   logic                      accept;
   logic                      take;
   logic                      emit;
   dfim_pkg::rsp_payload_type result;
   dfim_pkg::req_payload_type item;
   logic                      kept;
   logic                      close_window;
   logic [dfim_pkg::PosWidth:0] reach;

   assign item   = req.payload;
   assign accept = req.valid && req.ready;
   assign take   = rsp.valid && rsp.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_threshold_ff <= dfim_pkg::DepthThresholdReset;
         merge_gap_ff       <= dfim_pkg::MergeGapReset;
         merge_enable_ff    <= dfim_pkg::MergeEnableReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            dfim_pkg::CSR_DEPTH_THRESHOLD:
               depth_threshold_ff <= csr_wr_data[dfim_pkg::DepthWidth-1:0];
            dfim_pkg::CSR_MERGE_GAP:
               merge_gap_ff <= csr_wr_data[dfim_pkg::PosWidth-1:0];
            dfim_pkg::CSR_MERGE_ENABLE:
               merge_enable_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // window end plus gap, one bit wider
   assign reach = {1'b0, window_end_ff} + {1'b0, merge_gap_ff};
   assign kept  = item.read_depth >= depth_threshold_ff;
   assign close_window = (window_seq_ff != item.seq_id) ||
                         (window_ploidy_ff != item.ploidy) ||
                         (reach < {1'b0, item.start_pos});

   // item decision and window update
   always_comb begin
      window_open_in   = window_open_ff;
      window_seq_in    = window_seq_ff;
      window_start_in  = window_start_ff;
      window_end_in    = window_end_ff;
      window_ploidy_in = window_ploidy_ff;
      emit             = 1'b0;
      result.out_seq_id = window_seq_ff;
      result.out_start  = window_start_ff;
      result.out_end    = window_end_ff;
      result.out_ploidy = window_ploidy_ff;
      if (accept) begin
         if (item.kind == dfim_pkg::KIND_FLUSH) begin
            emit           = window_open_ff;
            window_open_in = 1'b0;
         end else if (kept) begin
            if (!merge_enable_ff) begin
               // pass-through leaves the window alone
               emit              = 1'b1;
               result.out_seq_id = item.seq_id;
               result.out_start  = item.start_pos;
               result.out_end    = item.end_pos;
               result.out_ploidy = item.ploidy;
            end else if (!window_open_ff || close_window) begin
               emit             = window_open_ff;
               window_open_in   = 1'b1;
               window_seq_in    = item.seq_id;
               window_start_in  = item.start_pos;
               window_end_in    = item.end_pos;
               window_ploidy_in = item.ploidy;
            end else begin
               if (item.start_pos < window_start_ff) begin
                  window_start_in = item.start_pos;
               end
               if (item.end_pos > window_end_ff) begin
                  window_end_in = item.end_pos;
               end
            end
         end
      end
   end

   // output register and skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = emit;
            skid_data_in  = result;
         end else begin
            out_valid_in = emit;
            out_data_in  = result;
         end
      end else if (emit) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         window_open_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         window_open_ff <= window_open_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   // window contents reset to zero to match the window's defined reset
   always_ff @(posedge clock) begin
      if (reset) begin
         window_seq_ff    <= '0;
         window_start_ff  <= '0;
         window_end_ff    <= '0;
         window_ploidy_ff <= '0;
      end else begin
         window_seq_ff    <= window_seq_in;
         window_start_ff  <= window_start_in;
         window_end_ff    <= window_end_in;
         window_ploidy_ff <= window_ploidy_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req.ready   = !skid_valid_ff;
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_data_ff;

   // skid entry is only ever behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item with no result in front");

   // a stalled skid entry stays
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp.ready) |=> skid_valid_ff)
      else $error("skid item lost while output stalled");

   // a flush always closes the window
   a_flush_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && item.kind == dfim_pkg::KIND_FLUSH) |=> !window_open_ff)
      else $error("window still open after flush");

   // pass-through records leave the window untouched
   a_pass_keeps_window: assert property (@(posedge clock) disable iff (reset)
      (accept && item.kind == dfim_pkg::KIND_RECORD && !merge_enable_ff)
      |=> (window_open_ff == $past(window_open_ff)) &&
          (window_end_ff == $past(window_end_ff)))
      else $error("pass-through record changed the window");

endmodule

`default_nettype wire

/* tb/tb_depth_filtered_interval_merge_core.sv */
// Testbench of depth_filtered_interval_merge_core: directed and random record
// streams checked against a window-merge predictor. Needs dfim_pkg,
// dfim_stream_if and the core.
`timescale 1ns / 1ps

module tb_depth_filtered_interval_merge_core;

   typedef logic [dfim_pkg::DepthWidth-1:0]  depth_type;
   typedef logic [dfim_pkg::PosWidth-1:0]    pos_type;
   typedef logic [dfim_pkg::PosWidth+1:0]    wide_pos_type;
   typedef logic [dfim_pkg::SeqWidth-1:0]    seq_type;
   typedef logic [dfim_pkg::PloidyWidth-1:0] ploidy_type;
   typedef logic [dfim_pkg::CsrDataWidth-1:0] csr_data_type;

   localparam logic [dfim_pkg::PosWidth-1:0]    FieldMax      = '1;
   localparam logic [dfim_pkg::CsrIdxWidth-1:0] CsrSpareIndex = 2'd3;
   localparam int                               SettleCycles  = 4;

   logic clock = 1'b0;
   logic reset;
   logic                              csr_wr_en;
   logic [dfim_pkg::CsrIdxWidth-1:0]  csr_index;
   logic [dfim_pkg::CsrDataWidth-1:0] csr_wr_data;

   dfim_stream_if #(.payload_type(dfim_pkg::req_payload_type)) req_if ();
   dfim_stream_if #(.payload_type(dfim_pkg::rsp_payload_type)) rsp_if ();

   depth_filtered_interval_merge_core dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // predictor copy of the registers and the open window
   depth_type  cfg_depth_min = dfim_pkg::DepthThresholdReset;
   pos_type    cfg_gap       = dfim_pkg::MergeGapReset;
   logic       cfg_merge     = dfim_pkg::MergeEnableReset;
   logic       win_open      = 1'b0;
   seq_type    win_seq       = '0;
   pos_type    win_start     = '0;
   pos_type    win_end       = '0;
   ploidy_type win_ploidy    = '0;

   dfim_pkg::rsp_payload_type intervals_due[$];
   int  mismatches    = 0;
   bit  no_idle       = 1'b0;
   int  rsp_hold_req  = 0;

   // one item through the filter and the window; returns 1 when an interval leaves
   function automatic bit merge_step(input dfim_pkg::req_payload_type it,
                                     output dfim_pkg::rsp_payload_type iv);
      logic [dfim_pkg::PosWidth:0] reach;
      iv = '0;
      if (it.kind == dfim_pkg::KIND_FLUSH) begin
         if (!win_open) return 1'b0;
         iv = {win_seq, win_start, win_end, win_ploidy};
         win_open = 1'b0;
         return 1'b1;
      end
      if (it.read_depth < cfg_depth_min) return 1'b0;
      if (!cfg_merge) begin
         iv = {it.seq_id, it.start_pos, it.end_pos, it.ploidy};
         return 1'b1;
      end
      if (!win_open) begin
         {win_open, win_seq, win_start, win_end, win_ploidy} =
            {1'b1, it.seq_id, it.start_pos, it.end_pos, it.ploidy};
         return 1'b0;
      end
      // widened sum, no wrap at the top of the position range
      reach = {1'b0, win_end} + {1'b0, cfg_gap};
      if (it.seq_id != win_seq || it.ploidy != win_ploidy ||
          reach < {1'b0, it.start_pos}) begin
         iv = {win_seq, win_start, win_end, win_ploidy};
         {win_open, win_seq, win_start, win_end, win_ploidy} =
            {1'b1, it.seq_id, it.start_pos, it.end_pos, it.ploidy};
         return 1'b1;
      end
      if (it.start_pos < win_start) win_start = it.start_pos;
      if (it.end_pos > win_end) win_end = it.end_pos;
      return 1'b0;
   endfunction

   // idle length: mostly none or short, a few long
   function automatic int idle_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic dfim_pkg::req_payload_type variant_item(input depth_type depth,
                                                              input seq_type seq,
                                                              input pos_type s,
                                                              input pos_type e,
                                                              input ploidy_type p);
      return {dfim_pkg::KIND_RECORD, depth, seq, s, e, p};
   endfunction

   function automatic dfim_pkg::req_payload_type flush_item(input bit junk);
      dfim_pkg::req_payload_type it;
      it = junk ? '1 : '0;
      it.kind = dfim_pkg::KIND_FLUSH;
      return it;
   endfunction

   // offer one item after a random gap, predict once it is taken
   task automatic send_item(input dfim_pkg::req_payload_type it);
      int gap;
      dfim_pkg::rsp_payload_type iv;
      gap = idle_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= it;
      do @(posedge clock); while (!req_if.ready);
      if (merge_step(it, iv)) intervals_due.push_back(iv);
   endtask

   // stop offering, wait for every expected interval, then let the core settle
   task automatic drain();
      req_if.valid <= 1'b0;
      while (intervals_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [dfim_pkg::CsrIdxWidth-1:0] idx,
                            input csr_data_type value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         dfim_pkg::CSR_DEPTH_THRESHOLD: cfg_depth_min = value;
         dfim_pkg::CSR_MERGE_GAP:       cfg_gap = value;
         dfim_pkg::CSR_MERGE_ENABLE:    cfg_merge = value[0];
         default: ;
      endcase
   endtask

   // reset register values: filter edge, merge, jumps, seq and ploidy changes
   task automatic test_directed();
      send_item(flush_item(1'b0));                              // flush, no window
      send_item(variant_item(31'd9, 16'd0, 31'd100, 31'd200, 4'd2));   // below threshold
      send_item(variant_item(31'd10, 16'd0, 31'd100, 31'd200, 4'd2));  // opens window
      send_item(variant_item(FieldMax, 16'd0, 31'd200, 31'd250, 4'd2)); // touching end
      send_item(variant_item(31'd40, 16'd0, 31'd50, 31'd60, 4'd2));    // earlier start
      send_item(variant_item(31'd40, 16'd0, 31'd251, 31'd300, 4'd2));  // one past end
      send_item(variant_item(31'd40, 16'hFFFF, 31'd260, 31'd400, 4'd2)); // new seq
      send_item(variant_item(31'd40, 16'hFFFF, 31'd260, 31'd400, 4'd15)); // new ploidy
      send_item(variant_item(31'd40, 16'hFFFF, 31'd280, 31'd100, 4'd15)); // end before start
      send_item(variant_item(31'd40, 16'd1, FieldMax, 31'd0, 4'd0));
      send_item(variant_item(31'd40, 16'd1, 31'd0, FieldMax, 4'd0));
      send_item(flush_item(1'b1));                              // flush, junk fields
      send_item(flush_item(1'b1));                              // flush again, no window
      send_item(variant_item(31'd0, 16'd0, 31'd5, 31'd6, 4'd1));       // depth zero
      drain();
   endtask

   // register extremes, masking, spare index, mode switch with a window open
   task automatic test_registers();
      write_csr(dfim_pkg::CSR_DEPTH_THRESHOLD, '0);
      write_csr(dfim_pkg::CSR_MERGE_GAP, FieldMax);
      send_item(variant_item(31'd0, 16'd5, 31'd10, FieldMax, 4'd3));
      send_item(variant_item(31'd0, 16'd5, FieldMax, 31'd5, 4'd3));    // sum at the top
      drain();
      write_csr(dfim_pkg::CSR_MERGE_ENABLE, 31'd2);              // bit 0 clear: pass-through
      send_item(variant_item(31'd3, 16'd6, 31'd1, 31'd2, 4'd4));
      send_item(variant_item(31'd3, 16'd5, 31'd11, 31'd12, 4'd3));
      send_item(flush_item(1'b0));                              // leftover window leaves
      drain();
      write_csr(CsrSpareIndex, '0);
      write_csr(dfim_pkg::CSR_MERGE_ENABLE, 31'd1);
      write_csr(dfim_pkg::CSR_DEPTH_THRESHOLD, FieldMax);
      write_csr(dfim_pkg::CSR_MERGE_GAP, '0);
      send_item(variant_item(FieldMax - 31'd1, 16'd7, 31'd1, 31'd9, 4'd1));
      send_item(variant_item(FieldMax, 16'd7, 31'd1, 31'd9, 4'd1));
      send_item(flush_item(1'b0));
      drain();
   endtask

   // receiver holds off while records stream in until the core stalls its input
   task automatic test_backpressure();
      write_csr(dfim_pkg::CSR_DEPTH_THRESHOLD, '0);
      write_csr(dfim_pkg::CSR_MERGE_ENABLE, 31'd0);
      no_idle = 1'b1;
      rsp_hold_req = 80;
      for (int i = 0; i < 16; i++) begin
         send_item(variant_item(depth_type'($urandom), seq_type'($urandom),
                                pos_type'($urandom), pos_type'($urandom),
                                ploidy_type'($urandom)));
      end
      no_idle = 1'b0;
      drain();
   endtask

   // mostly sorted record streams with random content, some noise and flushes
   task automatic random_phase(input depth_type depth_min,
                               input pos_type gap,
                               input logic merge, input bit quiet, input int count);
      dfim_pkg::req_payload_type it;
      logic [127:0]        raw;
      wide_pos_type        pos, stop, depth;
      seq_type             seq;
      ploidy_type          ploidy;
      int r;
      drain();
      write_csr(dfim_pkg::CSR_DEPTH_THRESHOLD, depth_min);
      write_csr(dfim_pkg::CSR_MERGE_GAP, gap);
      write_csr(dfim_pkg::CSR_MERGE_ENABLE, csr_data_type'(merge));
      no_idle = quiet;
      seq = seq_type'($urandom_range(0, 3));
      ploidy = 4'd2;
      pos = wide_pos_type'($urandom_range(0, 1000));
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         raw = {$urandom, $urandom, $urandom, $urandom};
         it = raw[$bits(dfim_pkg::req_payload_type)-1:0];
         if (r >= 8 && r < 13) begin
            it.kind = dfim_pkg::KIND_FLUSH;
         end else if (r >= 13) begin
            if (r < 16) begin
               seq = seq_type'($urandom);
               pos = wide_pos_type'($urandom_range(0, 5000));
            end else if (r < 19) begin
               ploidy = ploidy_type'($urandom);
            end
            // right at the merge boundary of the open window, or a step along
            if (r >= 19 && r < 25 && win_open) begin
               seq = win_seq;
               ploidy = win_ploidy;
               pos = win_end + gap + $urandom_range(0, 1);
            end else if (r < 35) begin
               pos = pos + $urandom_range(50, 400);
            end else begin
               pos = pos + $urandom_range(0, 30);
            end
            if (pos > FieldMax) pos = FieldMax;
            stop = pos + $urandom_range(0, 60);
            if ($urandom_range(0, 29) == 0) stop = pos - $urandom_range(0, 20);
            if (stop > FieldMax) stop = FieldMax;
            // depth mostly at or above the threshold, some just below
            r = $urandom_range(0, 9);
            if (r < 7) depth = depth_min + $urandom_range(0, 100);
            else if (r < 9) depth = (depth_min > 5) ? depth_min - $urandom_range(1, 5) : '0;
            else depth = {2'b00, raw[127:97]};
            if (depth > FieldMax) depth = FieldMax;
            it = variant_item(depth[dfim_pkg::DepthWidth-1:0], seq,
                              pos[dfim_pkg::PosWidth-1:0],
                              stop[dfim_pkg::PosWidth-1:0], ploidy);
            if (pos > FieldMax - 100000) pos = wide_pos_type'($urandom_range(0, 1000));
         end
         send_item(it);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random();
      random_phase(dfim_pkg::DepthThresholdReset, dfim_pkg::MergeGapReset, 1'b1, 1'b0, 200);
      random_phase('0, 31'd100, 1'b1, 1'b1, 150);
      random_phase(31'($urandom_range(0, 1000)), FieldMax, 1'b1, 1'b0, 150);
      random_phase(31'd5, '0, 1'b0, 1'b0, 200);
      random_phase(FieldMax, 31'($urandom_range(1, 20)), 1'b1, 1'b0, 100);
      random_phase(31'd20, 31'd3, 1'b1, 1'b0, 200);
      send_item(flush_item(1'b0));
   endtask

   // receiver ready: random stretches high and low, long hold on request
   initial begin : rsp_ready_driver
      int  left;
      logic level;
      left = 0;
      level = 1'b1;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req > 0) begin
            level = 1'b0;
            left = rsp_hold_req;
            rsp_hold_req = 0;
         end else if (left <= 0) begin
            if (level) begin
               left = idle_len();
               if (left > 0) level = 1'b0;
               else left = $urandom_range(1, 20);
            end else begin
               level = 1'b1;
               left = $urandom_range(1, 20);
            end
         end
         rsp_if.ready <= level;
         left--;
      end
   end

   // compare each interval with the oldest expected one
   always @(posedge clock) begin : check_intervals
      dfim_pkg::rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (intervals_due.size() == 0) begin
            mismatches++;
            $error("interval with none expected: seq %0h start %0d end %0d",
                   rsp_if.payload.out_seq_id, rsp_if.payload.out_start,
                   rsp_if.payload.out_end);
         end else begin
            want = intervals_due.pop_front();
            if (rsp_if.payload.out_seq_id !== want.out_seq_id) begin
               mismatches++;
               $error("out_seq_id: expected %0h, got %0h", want.out_seq_id,
                      rsp_if.payload.out_seq_id);
            end
            if (rsp_if.payload.out_start !== want.out_start) begin
               mismatches++;
               $error("out_start: expected %0d, got %0d", want.out_start,
                      rsp_if.payload.out_start);
            end
            if (rsp_if.payload.out_end !== want.out_end) begin
               mismatches++;
               $error("out_end: expected %0d, got %0d", want.out_end,
                      rsp_if.payload.out_end);
            end
            if (rsp_if.payload.out_ploidy !== want.out_ploidy) begin
               mismatches++;
               $error("out_ploidy: expected %0d, got %0d", want.out_ploidy,
                      rsp_if.payload.out_ploidy);
            end
         end
      end
   end

   initial begin : main_sequence
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_registers();
      test_backpressure();
      test_random();
      drain();
      if (mismatches == 0) begin
         $display("** depth_filtered_interval_merge_core: PASSED **");
      end else begin
         $display("** depth_filtered_interval_merge_core: FAILED **");
      end
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin : watchdog
      #20_000_000;
      $display("** depth_filtered_interval_merge_core: FAILED **");
      $finish;
   end

endmodule

/* filelist.f */
design/dfim_pkg.sv
design/dfim_stream_if.sv
design/depth_filtered_interval_merge_core.sv
tb/tb_depth_filtered_interval_merge_core.sv
